// ===== sv/aps_pkg.sv =====
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types and constants for the approximate pattern search block.
// ----------------------------------------------------------------------------
package aps_pkg;

	localparam int PAT_MAX = 64;
	localparam int VEC_W   = 64;
	localparam int IDX_W   = $clog2(PAT_MAX);
	localparam int TOP_W   = $clog2(VEC_W);
	localparam int LEN_W   = 7;
	localparam int SCORE_W = 7;
	localparam int CODE_W  = 21;
	localparam int POS_W   = 32;

	// longest pattern the vectors can hold
	localparam logic [LEN_W-1:0] LEN_CAP =
		(PAT_MAX < VEC_W) ? LEN_W'(PAT_MAX) : LEN_W'(VEC_W);

	localparam logic [SCORE_W-1:0] SCORE_INIT = '1;
	localparam logic [POS_W-1:0]   POS_SAT    = '1;

	// configuration register indexes
	localparam logic REG_PATTERN_LENGTH = 1'b0;
	localparam logic REG_DIST_LIMIT     = 1'b1;

	// item actions
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TEXT = 1'b1;

	typedef struct packed {
		logic              action;
		logic [IDX_W-1:0]  pattern_index;
		logic [CODE_W-1:0] char_code;
		logic              text_last;
	} in_item_t;

	typedef struct packed {
		logic               found;
		logic [POS_W-1:0]   match_end;
		logic [SCORE_W-1:0] edit_dist;
	} out_item_t;

	typedef struct packed {
		logic [VEC_W-1:0]   pv;
		logic [VEC_W-1:0]   mv;
		logic [SCORE_W-1:0] score;
	} search_state_t;

endpackage

// ===== sv/aps_pattern_store.sv =====
// ----------------------------------------------------------------------------
// aps_pattern_store
// Pattern code point store with a parallel compare against one text item.
// ----------------------------------------------------------------------------
module aps_pattern_store import aps_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  widx,
	input  logic [CODE_W-1:0] wdata,
	input  logic [CODE_W-1:0] code,
	input  logic [LEN_W-1:0]  eff_len,
	output logic [VEC_W-1:0]  eq
);

	logic [CODE_W-1:0] store_q [PAT_MAX];

	always_ff @(posedge clk) begin
		if (we && ({1'b0, widx} < (IDX_W+1)'(PAT_MAX))) begin
			store_q[widx] <= wdata;
		end
	end

	// entries at or beyond the pattern length never take part
	always_comb begin
		eq = '0;
		for (int i = 0; i < PAT_MAX; i++) begin
			eq[i] = (LEN_W'(i) < eff_len) && (store_q[i] == code);
		end
	end

endmodule

// ===== sv/aps_myers_step.sv =====
// ----------------------------------------------------------------------------
// aps_myers_step
// One column of the bit-vector edit distance update.
// ----------------------------------------------------------------------------
module aps_myers_step import aps_pkg::*; (
	input  search_state_t    cur,
	input  logic [VEC_W-1:0] eq,
	input  logic [TOP_W-1:0] top,
	output search_state_t    nxt
);

	logic [VEC_W-1:0] xv, xh, ph, mh, ph_sh, mh_sh;

	always_comb begin
		xv    = eq | cur.mv;
		xh    = (((eq & cur.pv) + cur.pv) ^ cur.pv) | eq;
		ph    = cur.mv | ~(xh | cur.pv);
		mh    = cur.pv & xh;
		ph_sh = ph << 1;
		mh_sh = mh << 1;

		nxt.pv = mh_sh | ~(xv | ph_sh);
		nxt.mv = ph_sh & xv;

		// score follows the horizontal delta at the last pattern row
		if (ph[top]) begin
			nxt.score = cur.score + SCORE_W'(1);
		end else if (mh[top] && (cur.score != '0)) begin
			nxt.score = cur.score - SCORE_W'(1);
		end else begin
			nxt.score = cur.score;
		end
	end

endmodule

// ===== sv/approximate_pattern_search.sv =====
// ----------------------------------------------------------------------------
// approximate_pattern_search
// Streaming approximate match of a loaded pattern against a text.
// ----------------------------------------------------------------------------
// Use: load pattern code points with action = load (any load restarts the
// search), set pattern_length and the distance limit through the write port
// while idle, then stream text code points. The text item with text_last set
// gives one result item: found, match_end and edit_dist; other items
// give none. After that item the search state clears for the next text.
// Channels: in_valid / in_stall and out_valid / out_stall; an item moves on
// an edge with valid high and stall low.
// Path: an accepted item enters the input register; the result register
// loads as the last text item leaves it, and out_valid rises with it.
// Throughput: one item per cycle while no stalled result waits; the pattern
// compare and 64-bit carry add are combinational after the input register.
// Stall: a waiting result holds in the output register, and while it waits
// no item leaves the input register, result or not. The input stage stalls
// only when it is full and the output register is full and stalled.
// Reset: clears control and the search state to their defaults and the valid
// flags of both registers; the pattern store is not cleared and needs loading.
// ----------------------------------------------------------------------------
module approximate_pattern_search import aps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [LEN_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_item
);

	logic              valid_s1;
	in_item_t          item_s1;
	logic [LEN_W-1:0]  plen_q, maxd_q;
	search_state_t     srch_q;
	logic [SCORE_W-1:0] best_q;
	logic [POS_W-1:0]  best_end_q, pos_q;
	logic              out_valid_q;
	out_item_t         out_item_q;

	logic [LEN_W-1:0]  eff_len;
	logic [TOP_W-1:0]  top;
	logic [VEC_W-1:0]  eq;
	search_state_t     srch_nxt;
	logic [POS_W-1:0]  pos_nxt;
	logic              better, out_free, adv, is_text, is_last, found;
	logic [SCORE_W-1:0] best_nxt;
	logic [POS_W-1:0]  end_nxt;

	always_comb begin
		if (plen_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (plen_q > LEN_CAP) begin
			eff_len = LEN_CAP;
		end else begin
			eff_len = plen_q;
		end
	end

	assign top = TOP_W'(eff_len - LEN_W'(1));

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign is_text  = (item_s1.action == ACT_TEXT);
	assign is_last  = is_text && item_s1.text_last;

	aps_pattern_store u_store (
		.clk     (clk),
		.we      (adv && !is_text),
		.widx    (item_s1.pattern_index),
		.wdata   (item_s1.char_code),
		.code    (item_s1.char_code),
		.eff_len (eff_len),
		.eq      (eq)
	);

	aps_myers_step u_step (
		.cur (srch_q),
		.eq  (eq),
		.top (top),
		.nxt (srch_nxt)
	);

	always_comb begin
		pos_nxt  = (pos_q == POS_SAT) ? pos_q : pos_q + POS_W'(1);
		better   = srch_nxt.score < best_q;
		best_nxt = better ? srch_nxt.score : best_q;
		end_nxt  = better ? pos_nxt : best_end_q;
		found    = (best_nxt <= maxd_q) && (maxd_q <= eff_len);
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	// configuration and search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q       <= LEN_W'(1);
			maxd_q       <= '0;
			srch_q.pv    <= '1;
			srch_q.mv    <= '0;
			srch_q.score <= SCORE_W'(1);
			best_q       <= SCORE_INIT;
			best_end_q   <= '0;
			pos_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LENGTH: begin
					plen_q       <= cfg_data;
					srch_q.pv    <= '1;
					srch_q.mv    <= '0;
					if (cfg_data == '0) begin
						srch_q.score <= SCORE_W'(1);
					end else if (cfg_data > LEN_CAP) begin
						srch_q.score <= SCORE_W'(LEN_CAP);
					end else begin
						srch_q.score <= SCORE_W'(cfg_data);
					end
					best_q       <= SCORE_INIT;
					best_end_q   <= '0;
					pos_q        <= '0;
				end
				REG_DIST_LIMIT: begin
					maxd_q <= cfg_data;
				end
				default: begin
					maxd_q <= maxd_q;
				end
			endcase
		end else if (adv) begin
			if (!is_text || is_last) begin
				srch_q.pv    <= '1;
				srch_q.mv    <= '0;
				srch_q.score <= SCORE_W'(eff_len);
				best_q       <= SCORE_INIT;
				best_end_q   <= '0;
				pos_q        <= '0;
			end else begin
				srch_q     <= srch_nxt;
				best_q     <= best_nxt;
				best_end_q <= end_nxt;
				pos_q      <= pos_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && is_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_last) begin
			out_item_q.found     <= found;
			out_item_q.match_end <= found ? end_nxt : '0;
			out_item_q.edit_dist <= found ? best_nxt : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== sv/aps_checker.sv =====
// ----------------------------------------------------------------------------
// aps_checker
// Port-level checks on the result channel of the pattern search block.
// ----------------------------------------------------------------------------
module aps_checker import aps_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_stall,
	input out_item_t        out_item
);

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	// no match reports zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.found |->
			(out_item.match_end == '0) && (out_item.edit_dist == '0))
		else $error("miss result carries nonzero fields");

	// a match ends after at least one text item and is within the pattern
	a_hit_sane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.found |->
			(out_item.match_end != '0) && (out_item.edit_dist <= LEN_CAP))
		else $error("match result out of range");

	// a result may not rise straight out of reset
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(arst_n) && $past(arst_n, 2))
		else $error("result item without preceding input");

endmodule

bind approximate_pattern_search aps_checker u_aps_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the approximate pattern search block.
// A queue of items feeds a clocked driver that predicts each accepted item
// with a bit-vector edit-distance model; a clocked monitor checks each
// result against the oldest prediction. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
	import aps_pkg::*;

	localparam int TEXT_ITEMS = 1100;
	localparam int CALM_AT    = 900;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic             cfg_index = 1'b0;
	logic [LEN_W-1:0] cfg_data  = '0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	in_item_t         in_item   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_item_t        out_item;

	approximate_pattern_search u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// search model state
	logic [CODE_W-1:0]  pat_mem [PAT_MAX];
	logic [VEC_W-1:0]   vp, vn;
	logic [SCORE_W-1:0] dist_now, dist_best;
	logic [POS_W-1:0]   best_pos, text_pos;
	logic [LEN_W-1:0]   len_q  = 7'd1;
	logic [LEN_W-1:0]   maxd_q = 7'd0;

	in_item_t  pending_items [$];
	out_item_t expected_matches [$];
	out_item_t predicted, want_res;
	int        mismatch_count = 0;
	int        gap_left = 0;
	int        stall_left = 0;
	bit        burst_on = 1'b1;
	bit        calm = 1'b0;

	// generator view of the pattern store
	logic [CODE_W-1:0] gen_pat [PAT_MAX];
	logic [CODE_W-1:0] alpha [4];
	int                text_sent = 0;

	function automatic int eff_len();
		int m;
		m = int'(len_q);
		if (m < 1) m = 1;
		if (m > int'(LEN_CAP)) m = int'(LEN_CAP);
		return m;
	endfunction

	function automatic void restart_search();
		vp = '1;
		vn = '0;
		dist_now = SCORE_W'(eff_len());
		dist_best = SCORE_INIT;
		best_pos = '0;
		text_pos = '0;
	endfunction

	function automatic bit search_step(input in_item_t it, output out_item_t res);
		logic [VEC_W-1:0] eq, top, xv, xh, ph, mh;
		int m;
		res = '0;
		if (it.action == ACT_LOAD) begin
			if (int'(it.pattern_index) < PAT_MAX) pat_mem[it.pattern_index] = it.char_code;
			restart_search();
			return 1'b0;
		end
		m = eff_len();
		eq = '0;
		for (int i = 0; i < m; i++)
			if (pat_mem[i] == it.char_code) eq[i] = 1'b1;
		top = VEC_W'(1) << (m - 1);
		xv = eq | vn;
		xh = (((eq & vp) + vp) ^ vp) | eq;
		ph = vn | ~(xh | vp);
		mh = vp & xh;
		if ((ph & top) != '0) dist_now = dist_now + 1'b1;
		else if ((mh & top) != '0 && dist_now != '0) dist_now = dist_now - 1'b1;
		ph = ph << 1;
		mh = mh << 1;
		vp = mh | ~(xv | ph);
		vn = ph & xv;
		if (text_pos != POS_SAT) text_pos = text_pos + 1'b1;
		// only a strictly better score moves the end position
		if (dist_now < dist_best) begin
			dist_best = dist_now;
			best_pos = text_pos;
		end
		if (!it.text_last) return 1'b0;
		if (dist_best <= maxd_q && int'(maxd_q) <= m) begin
			res.found = 1'b1;
			res.match_end = best_pos;
			res.edit_dist = dist_best;
		end
		restart_search();
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("tb_top: mismatch at %0t: %s", $realtime, what);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				if (search_step(in_item, predicted)) expected_matches.push_back(predicted);
			end
			if (!in_valid || !in_stall) begin
				if (gap_left == 0 && !calm && burst_on && $urandom_range(0, 99) < 8)
					gap_left = $urandom_range(1, 12);
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					in_item <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_matches.size() == 0) begin
					report_mismatch("result item with nothing expected");
				end else begin
					want_res = expected_matches.pop_front();
					if (out_item.found !== want_res.found)
						report_mismatch($sformatf("found %0b, want %0b",
							out_item.found, want_res.found));
					if (out_item.match_end !== want_res.match_end)
						report_mismatch($sformatf("match_end %0d, want %0d",
							out_item.match_end, want_res.match_end));
					if (out_item.edit_dist !== want_res.edit_dist)
						report_mismatch($sformatf("edit_dist %0d, want %0d",
							out_item.edit_dist, want_res.edit_dist));
				end
			end
			if (stall_left == 0 && !calm && burst_on && $urandom_range(0, 99) < 10)
				stall_left = $urandom_range(1, 12);
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic push_item(input logic act, input int idx, input logic [CODE_W-1:0] code,
			input logic last);
		in_item_t it;
		it.action = act;
		it.pattern_index = (act == ACT_LOAD) ? IDX_W'(idx) : IDX_W'($urandom);
		it.char_code = code;
		it.text_last = (act == ACT_TEXT) ? last : 1'($urandom);
		pending_items.push_back(it);
		if (act == ACT_LOAD) gen_pat[idx] = code;
		else text_sent++;
	endtask

	function automatic logic [CODE_W-1:0] pick_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) return alpha[$urandom_range(0, 3)];
		if (r < 97) return CODE_W'($urandom_range(0, 21'h10FFFF));
		return CODE_W'($urandom);
	endfunction

	// pattern copy with edits and random flanks, ending in the last item
	task automatic send_text(input int m);
		logic [CODE_W-1:0] codes [$];
		int r, cut;
		repeat ($urandom_range(0, 4)) codes.push_back(pick_code());
		for (int i = 0; i < m; i++) begin
			r = $urandom_range(0, 99);
			if (r < 7) continue;
			codes.push_back((r < 14) ? pick_code() : gen_pat[i]);
			if (r >= 94) codes.push_back(pick_code());
		end
		repeat ($urandom_range(0, 3)) codes.push_back(pick_code());
		if (codes.size() == 0) codes.push_back(pick_code());
		// now and then a load breaks the text and restarts the search
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, codes.size() - 1) : -1;
		foreach (codes[i]) begin
			if (i == cut) push_item(ACT_LOAD, $urandom_range(0, PAT_MAX - 1), pick_code(), 1'b0);
			push_item(ACT_TEXT, 0, codes[i], i == codes.size() - 1);
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_matches.size() != 0);
		// items with no result may still be in flight
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [LEN_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_PATTERN_LENGTH) begin
			len_q = val;
			restart_search();
		end else begin
			maxd_q = val;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int r, m;
		logic [LEN_W-1:0]  len_w, maxd_w;
		logic [CODE_W-1:0] base;
		restart_search();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// length 1, limit 0 out of reset: exact hit, then a miss
		push_item(ACT_LOAD, 0, 21'h10FFFF, 1'b0);
		push_item(ACT_TEXT, 0, 21'h000000, 1'b0);
		push_item(ACT_TEXT, 0, 21'h10FFFF, 1'b1);
		push_item(ACT_TEXT, 0, 21'h1FFFFF, 1'b1);
		wait_idle();
		// zero length acts as one
		write_reg(REG_PATTERN_LENGTH, 7'd0);
		write_reg(REG_DIST_LIMIT, 7'd1);
		push_item(ACT_TEXT, 0, 21'h000000, 1'b1);
		wait_idle();
		write_reg(REG_PATTERN_LENGTH, 7'd3);
		write_reg(REG_DIST_LIMIT, 7'd1);
		push_item(ACT_LOAD, 0, 21'h61, 1'b0);
		push_item(ACT_LOAD, 1, 21'h62, 1'b0);
		push_item(ACT_LOAD, 2, 21'h63, 1'b0);
		push_item(ACT_LOAD, 63, 21'h155555, 1'b0);
		push_item(ACT_LOAD, 42, 21'h0AAAAA, 1'b0);
		// two exact hits: the first end is kept
		push_item(ACT_TEXT, 0, 21'h61, 1'b0);
		push_item(ACT_TEXT, 0, 21'h62, 1'b0);
		push_item(ACT_TEXT, 0, 21'h63, 1'b0);
		push_item(ACT_TEXT, 0, 21'h78, 1'b0);
		push_item(ACT_TEXT, 0, 21'h61, 1'b0);
		push_item(ACT_TEXT, 0, 21'h62, 1'b0);
		push_item(ACT_TEXT, 0, 21'h63, 1'b1);
		// load in mid text restarts the search
		push_item(ACT_TEXT, 0, 21'h61, 1'b0);
		push_item(ACT_LOAD, 2, 21'h63, 1'b0);
		push_item(ACT_TEXT, 0, 21'h62, 1'b0);
		push_item(ACT_TEXT, 0, 21'h63, 1'b1);
		wait_idle();
		// limit above the pattern length never matches
		write_reg(REG_DIST_LIMIT, 7'd4);
		push_item(ACT_TEXT, 0, 21'h61, 1'b0);
		push_item(ACT_TEXT, 0, 21'h62, 1'b0);
		push_item(ACT_TEXT, 0, 21'h63, 1'b1);

		text_sent = 0;
		while (text_sent < TEXT_ITEMS) begin
			wait_idle();
			calm = (text_sent > CALM_AT);
			burst_on = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 19);
			if (r == 0) len_w = 7'd0;
			else if (r == 1) len_w = 7'd64;
			else if (r == 2) len_w = LEN_W'($urandom_range(65, 127));
			else if (r == 3) len_w = LEN_W'($urandom_range(13, 63));
			else len_w = LEN_W'($urandom_range(1, 12));
			m = (len_w == 0) ? 1 : (len_w > LEN_CAP) ? int'(LEN_CAP) : int'(len_w);
			r = $urandom_range(0, 9);
			if (r == 0) maxd_w = 7'd0;
			else if (r == 1) maxd_w = LEN_W'(m);
			else if (r == 2) maxd_w = LEN_W'(m + 1);
			else if (r == 3) maxd_w = 7'd127;
			else if (r == 4) maxd_w = 7'd64;
			else maxd_w = LEN_W'($urandom_range(0, m));
			if ($urandom_range(0, 1) != 0) begin
				write_reg(REG_PATTERN_LENGTH, len_w);
				write_reg(REG_DIST_LIMIT, maxd_w);
			end else begin
				write_reg(REG_DIST_LIMIT, maxd_w);
				write_reg(REG_PATTERN_LENGTH, len_w);
			end
			base = ($urandom_range(0, 1) != 0) ? 21'h61 : CODE_W'($urandom_range(0, 21'h10FFF0));
			for (int k = 0; k < 4; k++) alpha[k] = base + CODE_W'(k);
			for (int i = 0; i < m; i++) push_item(ACT_LOAD, i, pick_code(), 1'b0);
			repeat ($urandom_range(2, 8)) send_text(m);
		end

		wait_idle();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0) $display("tb_top: PASS");
		else $display("tb_top: FAIL");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
